// File: rtl/core/itl_pkg.sv
// Shared types and constants of the interpolated table lookup
`timescale 1ns / 1ps

package itl_pkg;

	localparam int unsigned EW = 64;   // energy width, unsigned 40.24
	localparam int unsigned VW = 56;   // value width, signed 32.24
	localparam int unsigned DVW = 56;  // magnitude of a value difference
	localparam int unsigned QW = 57;   // kept quotient bits
	localparam int unsigned PW = 120;  // slope product width
	localparam int unsigned QOVF = 57; // first quotient bit that saturates

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_ZERO  = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_FIRST,
		S_CHK_FIRST,
		S_RD_LAST,
		S_CHK_LAST,
		S_RD_MID,
		S_CHK_MID,
		S_RD_LO,
		S_CAP_LO,
		S_CAP_HI,
		S_DIFF,
		S_MUL,
		S_DIV,
		S_SUM,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		RD_FIRST,
		RD_LAST,
		RD_MID,
		RD_LO,
		RD_HI
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    start;
		logic    short_res;
		logic    chk_last;
		logic    chk_mid;
		logic    cap_lo;
		logic    cap_hi;
		logic    zero_res;
		logic    diff;
		logic    mul_step;
		logic    div_step;
		logic    sum;
		rd_sel_t rd_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic is_short;
		logic first_hit;
		logic last_hit;
		logic search_done;
		logic zero_width;
		logic mul_last;
		logic div_last;
	} dp_sts_t;

endpackage

// File: rtl/core/interpolated_table_lookup.sv
// Top level of the interpolated table lookup
`timescale 1ns / 1ps

// Holds TABLE_COUNT tables of up to POINTS_PER_TABLE ascending (energy, value)
// points. A load transaction (func 0) with an in-range table and index writes
// one point and sets its table's length to point_index + 1; it gives no result.
// A query transaction (func 1) binary-searches its table, clamps to the first
// or last segment, and returns v0 + trunc((v1 - v0) * (e - e0) / (e1 - e0))
// saturated to signed 32.24, with a status. Items are handled one at a time.
// The query's divide is a 120-step restoring divider that makes one quotient
// bit per cycle; each search step reads the point memory through its
// registered read port and then compares. Short tables and zero-width
// segments finish without the multiply and divide. The point stores are
// not cleared at reset.
module interpolated_table_lookup #(
	parameter int unsigned TABLE_COUNT      = 4,
	parameter int unsigned POINTS_PER_TABLE = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [1:0]         table_id,
	input  logic [9:0]         point_index,
	input  logic [63:0]        energy,
	input  logic signed [55:0] point_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [55:0] result_value,
	output logic [1:0]         status
);

	import itl_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing
	itl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and arithmetic
	itl_dp #(
		.TABLE_COUNT      (TABLE_COUNT),
		.POINTS_PER_TABLE (POINTS_PER_TABLE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.table_id     (table_id),
		.point_index  (point_index),
		.energy       (energy),
		.point_value  (point_value),
		.result_value (result_value),
		.status       (status)
	);

endmodule

// File: rtl/core/itl_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module itl_ram #(
	parameter int unsigned WIDTH  = 64,
	parameter int unsigned DEPTH  = 4096,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/itl_dp.sv
// Datapath: point stores, table lengths, search, multiply, divide and saturate
`timescale 1ns / 1ps

module itl_dp #(
	parameter int unsigned TABLE_COUNT      = 4,
	parameter int unsigned POINTS_PER_TABLE = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  itl_pkg::dp_cmd_t     cmd,
	output itl_pkg::dp_sts_t     sts,
	input  logic [1:0]           table_id,
	input  logic [9:0]           point_index,
	input  logic [63:0]          energy,
	input  logic signed [55:0]   point_value,
	output logic signed [55:0]   result_value,
	output logic [1:0]           status
);

	import itl_pkg::*;

	localparam int unsigned DEPTH = TABLE_COUNT * POINTS_PER_TABLE;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned IW = $clog2(POINTS_PER_TABLE);
	localparam int unsigned LW = $clog2(POINTS_PER_TABLE + 1);
	localparam int unsigned TW = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
	localparam int unsigned CW = 7;

	logic [LW-1:0]     len_q [TABLE_COUNT];
	logic              tid_ok;
	logic              idx_ok;
	logic [LW-1:0]     len_sel;
	logic [AW-1:0]     in_base;
	logic              we;

	logic [AW-1:0]     base_q;
	logic [EW-1:0]     e_q;
	logic [IW-1:0]     lo_q;
	logic [IW-1:0]     hi_q;
	logic              is_short_q;
	logic [IW-1:0]     mid;
	logic [IW-1:0]     rd_idx;
	logic [AW-1:0]     raddr;
	logic [EW-1:0]     e_rdata;
	logic [VW-1:0]     v_rdata;

	logic [EW-1:0]     e0_q;
	logic [EW-1:0]     e1_q;
	logic [VW-1:0]     v0_q;
	logic [VW-1:0]     v1_q;
	logic [DVW:0]      dv;
	logic [DVW-1:0]    dvm_q;
	logic [EW-1:0]     dnm_q;
	logic [EW-1:0]     ddm_q;
	logic              neg_q;

	logic [2:0]        mul_cnt_q;
	logic [31:0]       a_half;
	logic [31:0]       b_half;
	logic [63:0]       pp_q;
	logic [1:0]        pp_sh_q;
	logic [PW-1:0]     pp_wide;
	logic [PW-1:0]     prod_q;

	logic [EW-1:0]     rem_q;
	logic [EW:0]       rem_sh;
	logic              q_bit;
	logic [QW-1:0]     quo_q;
	logic              ovf_q;
	logic [CW-1:0]     div_cnt_q;

	logic [VW+2:0]     sum_w;
	logic [VW-1:0]     res_q;
	status_t           st_q;

	// input decode for loads and query start
	assign tid_ok  = 7'(table_id) < 7'(TABLE_COUNT);
	assign idx_ok  = 17'(point_index) < 17'(POINTS_PER_TABLE);
	assign len_sel = tid_ok ? len_q[TW'(table_id)] : '0;
	assign in_base = AW'(TW'(table_id)) * AW'(POINTS_PER_TABLE);
	assign we      = cmd.load && tid_ok && idx_ok;

	// table lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(TABLE_COUNT); i++) begin
				len_q[i] <= '0;
			end
		end else if (we) begin
			len_q[TW'(table_id)] <= LW'(17'(point_index) + 17'd1);
		end
	end

	// point stores
	itl_ram #(.WIDTH(EW), .DEPTH(DEPTH), .ADDR_W(AW)) u_energy_ram (
		.clk   (clk),
		.we    (we),
		.waddr (in_base + AW'(point_index)),
		.wdata (energy),
		.raddr (raddr),
		.rdata (e_rdata)
	);

	itl_ram #(.WIDTH(VW), .DEPTH(DEPTH), .ADDR_W(AW)) u_value_ram (
		.clk   (clk),
		.we    (we),
		.waddr (in_base + AW'(point_index)),
		.wdata (point_value),
		.raddr (raddr),
		.rdata (v_rdata)
	);

	// read address select
	assign mid = IW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_FIRST: rd_idx = '0;
			RD_LAST:  rd_idx = hi_q;
			RD_MID:   rd_idx = mid;
			RD_LO:    rd_idx = lo_q;
			RD_HI:    rd_idx = IW'({1'b0, lo_q} + 1'b1);
			default:  rd_idx = lo_q;
		endcase
	end

	assign raddr = base_q + AW'(rd_idx);

	// status back to the controller
	assign sts.is_short    = is_short_q;
	assign sts.first_hit   = e_q <= e_rdata;
	assign sts.last_hit    = e_q >= e_rdata;
	assign sts.search_done = ({1'b0, hi_q} - {1'b0, lo_q}) <= (IW + 1)'(1);
	assign sts.zero_width  = e0_q == e1_q;
	assign sts.mul_last    = mul_cnt_q == 3'd4;
	assign sts.div_last    = div_cnt_q == '0;

	// search bounds and query energy
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			e_q        <= energy;
			base_q     <= in_base;
			lo_q       <= '0;
			hi_q       <= IW'(len_sel - LW'(1));
			is_short_q <= !tid_ok || (len_sel < LW'(2));
		end else if (cmd.chk_last) begin
			lo_q <= IW'(hi_q - IW'(1));
		end else if (cmd.chk_mid) begin
			if (e_q < e_rdata) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid;
			end
		end
	end

	// segment end points
	always_ff @(posedge clk) begin
		if (cmd.cap_lo) begin
			e0_q <= e_rdata;
			v0_q <= v_rdata;
		end
		if (cmd.cap_hi) begin
			e1_q <= e_rdata;
			v1_q <= v_rdata;
		end
	end

	// value difference of the segment end points
	assign dv = {v1_q[VW-1], v1_q} - {v0_q[VW-1], v0_q};

	// partial product operands, 32 bits each
	assign a_half = mul_cnt_q[0] ? 32'(dvm_q[DVW-1:32]) : dvm_q[31:0];
	assign b_half = mul_cnt_q[1] ? dnm_q[63:32] : dnm_q[31:0];

	always_comb begin
		unique case (pp_sh_q)
			2'd0:    pp_wide = PW'(pp_q);
			2'd1:    pp_wide = PW'({pp_q, 32'd0});
			2'd2:    pp_wide = {pp_q[PW-65:0], 64'd0};
			default: pp_wide = '0;
		endcase
	end

	// one restoring division step
	assign rem_sh = {rem_q, prod_q[PW-1]};
	assign q_bit  = rem_sh >= {1'b0, ddm_q};

	// multiply and divide
	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			dvm_q     <= DVW'(dv[DVW] ? -dv : dv);
			dnm_q     <= (e_q >= e0_q) ? e_q - e0_q : e0_q - e_q;
			ddm_q     <= (e1_q >= e0_q) ? e1_q - e0_q : e0_q - e1_q;
			neg_q     <= dv[DVW] ^ (e_q < e0_q) ^ (e1_q < e0_q);
			prod_q    <= '0;
			mul_cnt_q <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			ovf_q     <= 1'b0;
			div_cnt_q <= CW'(PW - 1);
		end else if (cmd.mul_step) begin
			if (mul_cnt_q < 3'd4) begin
				pp_q    <= a_half * b_half;
				pp_sh_q <= 2'({1'b0, mul_cnt_q[0]} + {1'b0, mul_cnt_q[1]});
			end
			if (mul_cnt_q != 3'd0) begin
				prod_q <= prod_q + pp_wide;
			end
			mul_cnt_q <= mul_cnt_q + 3'd1;
		end else if (cmd.div_step) begin
			rem_q     <= q_bit ? EW'(rem_sh - {1'b0, ddm_q}) : EW'(rem_sh);
			prod_q    <= prod_q << 1;
			quo_q     <= {quo_q[QW-2:0], q_bit};
			ovf_q     <= ovf_q | (q_bit && (div_cnt_q >= CW'(QOVF)));
			div_cnt_q <= div_cnt_q - CW'(1);
		end
	end

	// final add with saturation
	assign sum_w = neg_q ? {{3{v0_q[VW-1]}}, v0_q} - {2'b00, quo_q}
	                     : {{3{v0_q[VW-1]}}, v0_q} + {2'b00, quo_q};

	always_ff @(posedge clk) begin
		if (cmd.short_res) begin
			res_q <= '0;
			st_q  <= ST_SHORT;
		end else if (cmd.zero_res) begin
			res_q <= v0_q;
			st_q  <= ST_ZERO;
		end else if (cmd.sum) begin
			if (ovf_q) begin
				res_q <= neg_q ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
				st_q  <= ST_SAT;
			end else if (sum_w[VW+2:VW-1] != {4{sum_w[VW+2]}}) begin
				res_q <= sum_w[VW+2] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
				st_q  <= ST_SAT;
			end else begin
				res_q <= sum_w[VW-1:0];
				st_q  <= ST_OK;
			end
		end
	end

	assign result_value = res_q;
	assign status       = st_q;

endmodule

// File: rtl/core/itl_ctrl.sv
// Controller state machine sequencing loads and queries
`timescale 1ns / 1ps

module itl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             func,
	output logic             out_valid,
	input  logic             out_stall,
	input  itl_pkg::dp_sts_t sts,
	output itl_pkg::dp_cmd_t cmd
);

	import itl_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = RD_LO;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (func == FUNC_QUERY) begin
						cmd.start = 1'b1;
						state_d   = S_RD_FIRST;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_RD_FIRST: begin
				if (sts.is_short) begin
					cmd.short_res = 1'b1;
					state_d       = S_DONE;
				end else begin
					cmd.rd_sel = RD_FIRST;
					state_d    = S_CHK_FIRST;
				end
			end
			S_CHK_FIRST: begin
				state_d = sts.first_hit ? S_RD_LO : S_RD_LAST;
			end
			S_RD_LAST: begin
				cmd.rd_sel = RD_LAST;
				state_d    = S_CHK_LAST;
			end
			S_CHK_LAST: begin
				if (sts.last_hit) begin
					cmd.chk_last = 1'b1;
					state_d      = S_RD_LO;
				end else begin
					state_d = S_RD_MID;
				end
			end
			S_RD_MID: begin
				if (sts.search_done) begin
					state_d = S_RD_LO;
				end else begin
					cmd.rd_sel = RD_MID;
					state_d    = S_CHK_MID;
				end
			end
			S_CHK_MID: begin
				cmd.chk_mid = 1'b1;
				state_d     = S_RD_MID;
			end
			S_RD_LO: begin
				cmd.rd_sel = RD_LO;
				state_d    = S_CAP_LO;
			end
			S_CAP_LO: begin
				cmd.cap_lo = 1'b1;
				cmd.rd_sel = RD_HI;
				state_d    = S_CAP_HI;
			end
			S_CAP_HI: begin
				cmd.cap_hi = 1'b1;
				state_d    = S_DIFF;
			end
			S_DIFF: begin
				if (sts.zero_width) begin
					cmd.zero_res = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.diff = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = state_q == S_DONE;

endmodule
